>>> hw/rtl/d2i_pkg.sv
// Package for the double to integer saturating converter.
// Holds the mode codes, limit constants and the payload types; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package d2i_pkg;
   typedef enum logic [1:0] {
      MODE_S64 = 2'd0,
      MODE_U64 = 2'd1,
      MODE_S32 = 2'd2,
      MODE_NONE = 2'd3
   } mode_type;

   localparam logic [63:0] SGN64_MAX = 64'h7fff_ffff_ffff_ffff;
   localparam logic [63:0] SGN64_MIN = 64'h8000_0000_0000_0000;
   localparam logic [63:0] ALL_ONES  = 64'hffff_ffff_ffff_ffff;
   localparam logic [63:0] SGN32_MAX = 64'h0000_0000_7fff_ffff;
   localparam logic [63:0] SGN32_MIN = 64'hffff_ffff_8000_0000;
   localparam logic [10:0] EXP_BIAS  = 11'd1023;
   localparam logic [10:0] EXP_ALL   = 11'h7ff;

   typedef struct packed {
      logic [1:0]  command;
      logic [63:0] value_bits;
   } req_type;

   typedef struct packed {
      logic [63:0] result_bits;
   } rsp_type;

   // Decoded operand passed from the decode logic to the saturation logic.
   typedef struct packed {
      logic [1:0]  command;
      logic        neg;
      logic        nan;
      logic        big;
      logic [63:0] mag;
   } dec_type;
endpackage
`default_nettype wire

>>> hw/rtl/d2i_if.sv
// Valid/ready channel interface carrying one payload.
// Depends on nothing; the payload type is set by the instantiating scope.
`timescale 1ns / 1ps
`default_nettype none
interface d2i_if #(parameter type payload_type = logic) (input wire logic clock);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/d2i_decode.sv
// Decodes the binary64 operand into sign, NaN, overflow and truncated magnitude.
// Depends on d2i_pkg.
`timescale 1ns / 1ps
`default_nettype none
module d2i_decode (
   input  wire logic [1:0]     command,
   input  wire logic [63:0]    value_bits,
   output d2i_pkg::dec_type    dec
);
   logic [10:0] expo;
   logic [51:0] frac;
   logic [52:0] sig;
   logic [10:0] k;

   always_comb begin
      expo = value_bits[62:52];
      frac = value_bits[51:0];
      sig = {1'b1, frac};
      k = expo - d2i_pkg::EXP_BIAS;
      dec.command = command;
      dec.neg = value_bits[63];
      dec.nan = (expo == d2i_pkg::EXP_ALL) && (frac != 52'd0);
      dec.big = 1'b0;
      dec.mag = 64'd0;
      if (expo == d2i_pkg::EXP_ALL) begin
         dec.big = 1'b1;
         dec.mag = d2i_pkg::ALL_ONES;
      end else if (expo < d2i_pkg::EXP_BIAS) begin
         dec.mag = 64'd0;
      end else if (k >= 11'd64) begin
         dec.big = 1'b1;
         dec.mag = d2i_pkg::ALL_ONES;
      end else if (k >= 11'd52) begin
         dec.mag = {11'd0, sig} << (k[5:0] - 6'd52);
      end else begin
         dec.mag = {11'd0, sig} >> (6'd52 - k[5:0]);
      end
   end
endmodule
`default_nettype wire

>>> hw/rtl/d2i_saturate.sv
// Applies the per-mode saturation rules to a decoded operand.
// Depends on d2i_pkg.
`timescale 1ns / 1ps
`default_nettype none
module d2i_saturate (
   input  wire d2i_pkg::dec_type dec,
   output logic [63:0]           result_bits
);
   logic [63:0] s64;
   logic [63:0] s32;
   logic [63:0] neg_mag;

   always_comb begin
      neg_mag = 64'd0 - dec.mag;
      if (dec.nan) s64 = d2i_pkg::SGN64_MIN;
      else if (!dec.neg) s64 = (dec.big || dec.mag[63]) ? d2i_pkg::SGN64_MAX : dec.mag;
      else if (dec.big || dec.mag[63]) s64 = d2i_pkg::SGN64_MIN;
      else s64 = neg_mag;

      if (dec.nan) s32 = d2i_pkg::SGN32_MIN;
      else if (!dec.neg)
         s32 = (dec.big || dec.mag >= d2i_pkg::SGN32_MAX) ? d2i_pkg::SGN32_MAX : dec.mag;
      else if (dec.big || dec.mag >= 64'h8000_0000) s32 = d2i_pkg::SGN32_MIN;
      else s32 = neg_mag;

      unique case (d2i_pkg::mode_type'(dec.command))
         d2i_pkg::MODE_S64: result_bits = s64;
         d2i_pkg::MODE_U64: begin
            if (!dec.nan && !dec.neg) result_bits = dec.big ? d2i_pkg::ALL_ONES : dec.mag;
            else result_bits = s64;
         end
         d2i_pkg::MODE_S32: result_bits = s32;
         default: result_bits = 64'd0;
      endcase
   end
endmodule
`default_nettype wire

>>> hw/rtl/double_to_integer_saturating_convert_core.sv
// Top level of the double to integer saturating converter.
// Depends on d2i_pkg, d2i_if, d2i_decode and d2i_saturate.
//
//   channel   direction   payload
//   req       in          command[1:0], value_bits[63:0]
//   rsp       out         result_bits[63:0]
//
// Each transfer passes through the input register, then the result register.
// Decode and saturation both sit between the two; one item moves per cycle unless
// rsp stalls. Reset clears both valid flags. A stalled rsp holds its stage; a
// stage loads whenever it is empty or the stage after it moves.
`timescale 1ns / 1ps
`default_nettype none
module double_to_integer_saturating_convert_core (
   input wire logic clock,
   input wire logic reset,
   d2i_if.sink      req,
   d2i_if.source    rsp
);
   logic             in_vld_ff, in_vld_in;
   d2i_pkg::req_type in_ff;
   logic             out_vld_ff, out_vld_in;
   logic [63:0]      out_ff;
   logic             out_load, in_load;
   d2i_pkg::dec_type dec;
   logic [63:0]      res;

   d2i_decode u_dec (
      .command(in_ff.command), .value_bits(in_ff.value_bits), .dec(dec));
   d2i_saturate u_sat (.dec(dec), .result_bits(res));

   always_comb begin
      out_load = !out_vld_ff || rsp.ready;
      in_load = !in_vld_ff || out_load;
      req.ready = in_load;
      in_vld_in = in_load ? req.valid : in_vld_ff;
      out_vld_in = out_load ? in_vld_ff : out_vld_ff;
      rsp.valid = out_vld_ff;
      rsp.payload.result_bits = out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
      if (in_load) in_ff <= req.payload;
      if (out_load) out_ff <= res;
   end
endmodule
`default_nettype wire

>>> hw/rtl/d2i_checker.sv
// Port-level checker for the converter, bound to the top level.
// Depends on d2i_pkg and the top level's ports.
`timescale 1ns / 1ps
`default_nettype none
module d2i_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic [1:0]  req_command,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [63:0] rsp_result
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result))
      else $error("result changed under stall");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("input stalled while output free");
   a_unused: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_command == d2i_pkg::MODE_NONE ##1 rsp_ready
      |=> (rsp_valid && rsp_result == 64'd0))
      else $error("unused mode gave nonzero");
   a_rst: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("valid after reset");
endmodule

bind double_to_integer_saturating_convert_core d2i_checker u_chk (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready), .req_command(req.payload.command),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_result(rsp.payload.result_bits));
`default_nettype wire

>>> verif/testbench.sv
// Self-checking testbench for the double to integer saturating converter.
// Depends on d2i_pkg, d2i_if and double_to_integer_saturating_convert_core.
// A local conversion function predicts each result; transfers are compared in order.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
   logic clock = 1'b0;
   logic reset = 1'b1;
   int   cycle_count = 0;

   d2i_if #(.payload_type(d2i_pkg::req_type)) req_ch (clock);
   d2i_if #(.payload_type(d2i_pkg::rsp_type)) rsp_ch (clock);

   double_to_integer_saturating_convert_core uut (
      .clock(clock), .reset(reset), .req(req_ch.sink), .rsp(rsp_ch.source)
   );

   d2i_pkg::req_type pending_ops[$];
   logic [63:0]      expected_ints[$];
   int               mismatch_count = 0;
   int               send_idle_pct = 19;
   int               recv_idle_pct = 77;
   int               hold_cycles = 0;
   bit               stim_done = 1'b0;

   function automatic logic [63:0] convert_double(d2i_pkg::mode_type mode,
                                                  logic [63:0] bits);
      logic        neg;
      logic        nan;
      logic        big;
      logic [63:0] mag;
      logic [10:0] expo;
      logic [52:0] sig;
      int          shift;
      neg = bits[63];
      expo = bits[62:52];
      nan = (expo == d2i_pkg::EXP_ALL) && (bits[51:0] != 52'd0);
      big = 1'b0;
      mag = 64'd0;
      sig = {1'b1, bits[51:0]};
      if (expo == d2i_pkg::EXP_ALL) begin
         big = 1'b1;
      end else if (expo >= d2i_pkg::EXP_BIAS) begin
         shift = int'(expo) - 1023;
         if (shift >= 64) begin
            big = 1'b1;
         end else if (shift >= 52) begin
            mag = {11'd0, sig} << (shift - 52);
         end else begin
            mag = {11'd0, sig} >> (52 - shift);
         end
      end
      case (mode)
         d2i_pkg::MODE_S32: begin
            if (nan) return d2i_pkg::SGN32_MIN;
            if (!neg) return (big || mag >= d2i_pkg::SGN32_MAX) ? d2i_pkg::SGN32_MAX : mag;
            if (big || mag >= 64'h8000_0000) return d2i_pkg::SGN32_MIN;
            return 64'd0 - mag;
         end
         d2i_pkg::MODE_NONE: return 64'd0;
         default: begin
            if (mode == d2i_pkg::MODE_U64 && !nan && !neg)
               return big ? d2i_pkg::ALL_ONES : mag;
            if (nan) return d2i_pkg::SGN64_MIN;
            if (!neg)
               return (big || mag >= d2i_pkg::SGN64_MIN) ? d2i_pkg::SGN64_MAX : mag;
            if (big || mag >= d2i_pkg::SGN64_MIN) return d2i_pkg::SGN64_MIN;
            return 64'd0 - mag;
         end
      endcase
   endfunction

   function automatic logic [63:0] random_double();
      logic [63:0] bits;
      int          pick;
      bits = {$urandom, $urandom};
      pick = $urandom_range(0, 9);
      case (pick)
         0, 1, 2: bits[62:52] = 11'(1023 + $urandom_range(0, 31));
         3, 4: bits[62:52] = 11'(1023 + $urandom_range(30, 66));
         5: bits[62:52] = $urandom_range(0, 1) ? d2i_pkg::EXP_ALL : 11'd0;
         6: bits[62:52] = 11'(1023 - $urandom_range(1, 3));
         7: bits[51:0] = $urandom_range(0, 1) ? 52'd0 : {52{1'b1}};
         default: ;
      endcase
      return bits;
   endfunction

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      logic [63:0]       corners[$];
      d2i_pkg::mode_type mode;
      corners = '{64'h0, 64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001,
                  64'h3ff0_0000_0000_0000, 64'hbff0_0000_0000_0000,
                  64'h3fef_ffff_ffff_ffff, 64'h43e0_0000_0000_0000,
                  64'hc3e0_0000_0000_0000, 64'h43f0_0000_0000_0000,
                  64'h43ef_ffff_ffff_ffff, 64'h41df_ffff_ffc0_0000,
                  64'h41e0_0000_0000_0000, 64'hc1e0_0000_0000_0000,
                  64'hc1e0_0000_0020_0000, 64'h7ff0_0000_0000_0000,
                  64'hfff0_0000_0000_0000, 64'h7ff8_0000_0000_0001,
                  64'hffff_ffff_ffff_ffff, 64'h4330_0000_0000_0001,
                  64'hc010_0000_0000_0000};
      foreach (corners[i]) begin
         pending_ops.push_back('{command: d2i_pkg::MODE_S64, value_bits: corners[i]});
         pending_ops.push_back('{command: d2i_pkg::MODE_U64, value_bits: corners[i]});
         pending_ops.push_back('{command: d2i_pkg::MODE_S32, value_bits: corners[i]});
      end
      pending_ops.push_back('{command: d2i_pkg::MODE_NONE,
                              value_bits: 64'h3ff0_0000_0000_0000});
      for (int n = 0; n < 790; n++) begin
         mode = d2i_pkg::mode_type'($urandom_range(0, 15) == 0 ? 3 : $urandom_range(0, 2));
         pending_ops.push_back('{command: mode, value_bits: random_double()});
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      wait (pending_ops.size() < 530);
      send_idle_pct = 0;
      hold_cycles = 200;
      wait (hold_cycles == 0);
      send_idle_pct = 77;
      recv_idle_pct = 19;
      wait (pending_ops.size() < 270);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      wait (pending_ops.size() == 0);
      stim_done = 1'b1;
   end

   // Driver: offers the next pending item unless idling this cycle.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.payload <= '0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            expected_ints.push_back(convert_double(
               d2i_pkg::mode_type'(req_ch.payload.command), req_ch.payload.value_bits));
            void'(pending_ops.pop_front());
         end
         if ((!req_ch.valid || req_ch.ready) && pending_ops.size() > 0) begin
            if ($urandom_range(0, 99) >= send_idle_pct) begin
               req_ch.valid <= 1'b1;
               req_ch.payload <= pending_ops[0];
            end else begin
               req_ch.valid <= 1'b0;
            end
         end else if (req_ch.valid && req_ch.ready) begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // The long receiver hold is counted down here.
   always @(posedge clock) begin
      if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
   end

   // Monitor: checks each result transfer and drives ready.
   always @(posedge clock) begin
      logic [63:0] want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_ints.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Unexpected result transfer: %h", rsp_ch.payload.result_bits);
            end else begin
               want = expected_ints.pop_front();
               if (want !== rsp_ch.payload.result_bits) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("Mismatch: expected %h, actual %h", want,
                              rsp_ch.payload.result_bits);
               end
            end
         end
         if (hold_cycles > 0) begin
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 200000) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      wait (stim_done);
      @(posedge clock);
      wait (!req_ch.valid && expected_ints.size() == 0);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && expected_ints.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
`default_nettype wire

>>> filelist.f
hw/rtl/d2i_pkg.sv
hw/rtl/d2i_if.sv
hw/rtl/d2i_decode.sv
hw/rtl/d2i_saturate.sv
hw/rtl/double_to_integer_saturating_convert_core.sv
hw/rtl/d2i_checker.sv
verif/testbench.sv
